// ===== design/swpb_pkg.sv =====
package swpb_pkg;

    localparam int LAYERS     = 4;
    localparam int WEIGHT_W   = 8;
    localparam int SEL_W      = 2;
    localparam int Q16_W      = 17;
    localparam int STRENGTH_W = 16;

    localparam logic [Q16_W-1:0]      ONE_Q16        = 17'h10000;
    localparam logic [Q16_W:0]        THREE_Q16      = 18'd196608;
    localparam logic [STRENGTH_W-1:0] STRENGTH_RESET = 16'd256;
    localparam logic [WEIGHT_W-1:0]   WEIGHT_MAX     = 8'd255;

    // register index decoded from paddr[2]
    localparam logic REG_STRENGTH = 1'b0;

    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef weight_t [LAYERS-1:0] texel_t;
    typedef logic [SEL_W-1:0] layer_t;
    typedef logic [Q16_W-1:0] q16_t;

    typedef struct packed {
        layer_t sel;
        logic   outside;
    } lane_ctl_t;

    typedef struct packed {
        lane_ctl_t ctl;
        texel_t    w;
    } side_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } falloff_adv_t;

endpackage

// ===== design/swpb_falloff.sv =====
module swpb_falloff (
    input  logic                       aclk,
    input  swpb_pkg::falloff_adv_t     adv,
    input  swpb_pkg::q16_t             ratio,
    input  logic signed [15:0]         strength,
    output swpb_pkg::q16_t             amount
);

    swpb_pkg::q16_t t;
    logic [17:0]    poly;
    logic [33:0]    tt_full;
    logic [32:0]    tt_reg;
    logic [17:0]    poly_reg;

    logic [50:0]    p_full;
    logic [49:0]    p_rnd;
    swpb_pkg::q16_t falloff_reg;

    logic [31:0]    s_prod;
    logic [32:0]    s_rnd;
    logic [24:0]    scaled;
    swpb_pkg::q16_t amount_next;
    swpb_pkg::q16_t amount_reg;

    assign t       = swpb_pkg::ONE_Q16 - ratio;
    assign poly    = swpb_pkg::THREE_Q16 - {t, 1'b0};
    assign tt_full = 34'(t) * 34'(t);

    // smoothstep: t*t*(3 - 2t) in Q1.16, rounded half up
    assign p_full = 51'(tt_reg) * 51'(poly_reg);
    assign p_rnd  = p_full[49:0] + 50'h0_8000_0000;

    assign s_prod = 32'(strength[14:0]) * 32'(falloff_reg);
    assign s_rnd  = 33'(s_prod) + 33'd128;
    assign scaled = s_rnd[32:8];

    always_comb begin
        if (strength[15] || strength == 16'sd0) begin
            amount_next = '0;
        end else if (scaled > 25'(swpb_pkg::ONE_Q16)) begin
            amount_next = swpb_pkg::ONE_Q16;
        end else begin
            amount_next = scaled[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s1) begin
            tt_reg   <= tt_full[32:0];
            poly_reg <= poly;
        end
        if (adv.s2) begin
            falloff_reg <= p_rnd[48:32];
        end
        if (adv.s3) begin
            amount_reg <= amount_next;
        end
    end

    assign amount = amount_reg;

endmodule

// ===== design/swpb_lane.sv =====
module swpb_lane (
    input  logic              aclk,
    input  logic              en,
    input  swpb_pkg::weight_t w,
    input  logic              painted,
    input  logic              outside,
    input  swpb_pkg::q16_t    amount,
    output swpb_pkg::weight_t w_out
);

    swpb_pkg::weight_t coef;
    logic [24:0]       mult;
    logic [25:0]       base;
    logic [25:0]       mixed;
    logic [25:0]       rnd;
    logic [9:0]        vq;
    swpb_pkg::weight_t blended;
    swpb_pkg::weight_t w_out_reg;

    // painted: w + (255-w)*a, others: w - w*a, both over 2^16
    assign coef  = painted ? (swpb_pkg::WEIGHT_MAX - w) : w;
    assign mult  = 25'(coef) * 25'(amount);
    assign base  = {2'b00, w, 16'h0000};
    assign mixed = painted ? (base + 26'(mult)) : (base - 26'(mult));
    assign rnd   = mixed + 26'd32768;
    assign vq    = rnd[25:16];

    always_comb begin
        if (vq > 10'(swpb_pkg::WEIGHT_MAX)) begin
            blended = swpb_pkg::WEIGHT_MAX;
        end else begin
            blended = vq[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_out_reg <= outside ? w : blended;
        end
    end

    assign w_out = w_out_reg;

endmodule

// ===== design/swpb_merge.sv =====
module swpb_merge (
    input  logic                aclk,
    input  logic                en,
    input  swpb_pkg::lane_ctl_t ctl,
    input  swpb_pkg::texel_t    w_lane,
    output swpb_pkg::texel_t    w_out,
    output logic                touched
);

    logic [9:0]         sum;
    logic signed [10:0] corr;
    swpb_pkg::weight_t  fixed_w;
    swpb_pkg::texel_t   w_fix;
    swpb_pkg::texel_t   w_out_reg;
    logic               touched_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < swpb_pkg::LAYERS; i++) begin
            sum = sum + 10'(w_lane[i]);
        end
    end

    // push the painted channel (clamped to 0..255) toward a weight sum of 255; outside texels pass
    assign corr = $signed({3'b000, w_lane[ctl.sel]}) + 11'sd255 - $signed({1'b0, sum});

    always_comb begin
        if (corr < 11'sd0) begin
            fixed_w = '0;
        end else if (corr > 11'sd255) begin
            fixed_w = swpb_pkg::WEIGHT_MAX;
        end else begin
            fixed_w = corr[7:0];
        end
        w_fix = w_lane;
        if (!ctl.outside) begin
            w_fix[ctl.sel] = fixed_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            w_out_reg   <= w_fix;
            touched_reg <= ~ctl.outside;
        end
    end

    assign w_out   = w_out_reg;
    assign touched = touched_reg;

endmodule

// ===== design/splat_weight_paint_blend.sv =====
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | tdata: ratio, weight 0..3; tuser: layer select
// m_      | out       | m_tvalid/m_tready  | tdata: weight 0..3; tuser: touched
// apb     | in        | psel/penable       | brush_strength at byte address 0
//
// One item per cycle unless m_tready stalls the output; each item passes from input to output through
// t*t, the smoothstep product, strength scaling, four parallel lanes, merge.
// The smoothstep multiply chain sets the depth; every stage has its own valid.
// aresetn (synchronous) clears all valids and sets brush_strength to 1.0.
// A stage holds while the next one is full and stalled; empty stages fill, so input stays
// open while a result waits on m_tready, as long as some stage is still empty.
module splat_weight_paint_blend (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // distance_ratio[16:0], weight_in_0..3 8 b each, zero pad
    input  logic [1:0]  s_tuser,   // paint_layer_sel[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // weight_out_0..3, 8 b each
    output logic [0:0]  m_tuser,   // touched

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]            strength_reg;
    logic [15:0]            strength_next;
    logic [4:0]             valid_reg;
    logic [4:0]             valid_next;
    logic [4:0]             rdy;

    swpb_pkg::q16_t         ratio;
    swpb_pkg::side_t        side_in;
    swpb_pkg::side_t        side1_reg;
    swpb_pkg::side_t        side2_reg;
    swpb_pkg::side_t        side3_reg;
    swpb_pkg::lane_ctl_t    ctl4_reg;
    swpb_pkg::falloff_adv_t f_adv;
    swpb_pkg::q16_t         amount;
    swpb_pkg::texel_t       w_lane;
    swpb_pkg::texel_t       w_out;
    logic                   touched;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == swpb_pkg::REG_STRENGTH) ? {16'h0000, strength_reg} : 32'h0;

    always_comb begin
        strength_next = strength_reg;
        if (psel && penable && pwrite && paddr[2] == swpb_pkg::REG_STRENGTH) begin
            strength_next = pwdata[15:0];
        end
    end

    // ready ripples back from the output register
    assign rdy[4] = ~valid_reg[4] | m_tready;
    assign rdy[3] = ~valid_reg[3] | rdy[4];
    assign rdy[2] = ~valid_reg[2] | rdy[3];
    assign rdy[1] = ~valid_reg[1] | rdy[2];
    assign rdy[0] = ~valid_reg[0] | rdy[1];

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[4];

    always_comb begin
        valid_next[0] = rdy[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < 5; k++) begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= swpb_pkg::STRENGTH_RESET;
            valid_reg    <= '0;
        end else begin
            strength_reg <= strength_next;
            valid_reg    <= valid_next;
        end
    end

    assign ratio               = s_tdata[16:0];
    assign side_in.ctl.sel     = s_tuser;
    assign side_in.ctl.outside = ratio > swpb_pkg::ONE_Q16;
    assign side_in.w[0]        = s_tdata[24:17];
    assign side_in.w[1]        = s_tdata[32:25];
    assign side_in.w[2]        = s_tdata[40:33];
    assign side_in.w[3]        = s_tdata[48:41];

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            side1_reg <= side_in;
        end
        if (rdy[1]) begin
            side2_reg <= side1_reg;
        end
        if (rdy[2]) begin
            side3_reg <= side2_reg;
        end
        if (rdy[3]) begin
            ctl4_reg <= side3_reg.ctl;
        end
    end

    assign f_adv.s1 = rdy[0];
    assign f_adv.s2 = rdy[1];
    assign f_adv.s3 = rdy[2];

    swpb_falloff u_falloff (
        .aclk     (aclk),
        .adv      (f_adv),
        .ratio    (ratio),
        .strength (strength_reg),
        .amount   (amount)
    );

    for (genvar i = 0; i < swpb_pkg::LAYERS; i++) begin : g_lane
        swpb_lane u_lane (
            .aclk    (aclk),
            .en      (rdy[3]),
            .w       (side3_reg.w[i]),
            .painted (side3_reg.ctl.sel == swpb_pkg::layer_t'(i)),
            .outside (side3_reg.ctl.outside),
            .amount  (amount),
            .w_out   (w_lane[i])
        );
    end

    swpb_merge u_merge (
        .aclk    (aclk),
        .en      (rdy[4]),
        .ctl     (ctl4_reg),
        .w_lane  (w_lane),
        .w_out   (w_out),
        .touched (touched)
    );

    assign m_tdata    = w_out;
    assign m_tuser[0] = touched;

endmodule

// ===== tb/splat_blend_checker.sv =====
module splat_blend_checker (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // distance_ratio[16:0], weight_in_0..3 8 b each, zero pad
    input  logic [1:0]  s_tuser,   // paint_layer_sel[1:0]

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // weight_out_0..3, 8 b each
    input  logic [0:0]  m_tuser,   // touched

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,

    output int          mismatch_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        swpb_pkg::texel_t w;
        logic             touched;
    } blended_texel_t;

    blended_texel_t       blended_q[$];
    logic signed [15:0]   strength_q;

    function automatic blended_texel_t blend_texel(input swpb_pkg::layer_t sel,
                                                   input swpb_pkg::q16_t ratio,
                                                   input swpb_pkg::texel_t w_in,
                                                   input logic signed [15:0] strength);
        blended_texel_t    res;
        longint unsigned   t;
        longint unsigned   falloff;
        longint unsigned   amount;
        longint unsigned   v;
        longint            sum;
        longint            corrected;
        res.w       = w_in;
        res.touched = 1'b0;
        if (ratio > swpb_pkg::ONE_Q16)
            return res;
        res.touched = 1'b1;
        t       = swpb_pkg::ONE_Q16 - ratio;
        falloff = (t * t * (swpb_pkg::THREE_Q16 - 2 * t) + 64'd2147483648) >> 32;
        if (strength <= 0) begin
            amount = 0;
        end else begin
            amount = (longint'(strength) * falloff + 128) >> 8;
            if (amount > swpb_pkg::ONE_Q16)
                amount = swpb_pkg::ONE_Q16;
        end
        sum = 0;
        for (int i = 0; i < swpb_pkg::LAYERS; i++) begin
            if (i == sel)
                v = (w_in[i] * 64'd65536 + (swpb_pkg::WEIGHT_MAX - w_in[i]) * amount
                     + 32768) >> 16;
            else
                v = (w_in[i] * (swpb_pkg::ONE_Q16 - amount) + 32768) >> 16;
            res.w[i] = (v > swpb_pkg::WEIGHT_MAX) ? swpb_pkg::WEIGHT_MAX
                                                   : v[swpb_pkg::WEIGHT_W-1:0];
            sum += longint'(res.w[i]);
        end
        // pull the sum back to full coverage through the painted layer
        corrected = longint'(res.w[sel]) + 255 - sum;
        if (corrected < 0)
            res.w[sel] = '0;
        else if (corrected > 255)
            res.w[sel] = swpb_pkg::WEIGHT_MAX;
        else
            res.w[sel] = corrected[swpb_pkg::WEIGHT_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        blended_texel_t exp_t;
        blended_texel_t got_t;
        if (!aresetn) begin
            strength_q = swpb_pkg::STRENGTH_RESET;
            blended_q.delete();
            pending_count = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == swpb_pkg::REG_STRENGTH)
                strength_q = pwdata[15:0];
            if (s_tvalid && s_tready) begin
                blended_q.insert(blended_q.size(),
                                 blend_texel(s_tuser, s_tdata[16:0], s_tdata[48:17],
                                             strength_q));
            end
            if (m_tvalid && m_tready) begin
                got_t.w       = m_tdata;
                got_t.touched = m_tuser[0];
                if (blended_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected texel out w=%h touched=%b",
                                 $realtime, got_t.w, got_t.touched);
                end else begin
                    exp_t = blended_q.pop_front();
                    if (got_t.w[0] !== exp_t.w[0] || got_t.w[1] !== exp_t.w[1] ||
                        got_t.w[2] !== exp_t.w[2] || got_t.w[3] !== exp_t.w[3] ||
                        got_t.touched !== exp_t.touched) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: texel mismatch w3..w0 exp %h got %h, ",
                                      "touched exp %b got %b"},
                                     $realtime, exp_t.w, got_t.w, exp_t.touched,
                                     got_t.touched);
                    end
                end
            end
            pending_count = blended_q.size();
        end
    end

endmodule

// ===== tb/splat_weight_paint_blend_tb.sv =====
module splat_weight_paint_blend_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int STEADY_PHASE    = 5;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // distance_ratio[16:0], weight_in_0..3 8 b each, zero pad
    logic [1:0]  s_tuser  = '0;   // paint_layer_sel[1:0]

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // weight_out_0..3, 8 b each
    logic [0:0]  m_tuser;         // touched

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        steady_run = 1'b0;
    int          mismatch_count;
    int          pending_count;

    splat_weight_paint_blend u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    splat_blend_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_tready <= steady_run || ($urandom_range(0, 99) >= 34);

    function automatic swpb_pkg::texel_t texel(input int w0, input int w1, input int w2,
                                               input int w3);
        swpb_pkg::texel_t w;
        w[0] = swpb_pkg::weight_t'(w0);
        w[1] = swpb_pkg::weight_t'(w1);
        w[2] = swpb_pkg::weight_t'(w2);
        w[3] = swpb_pkg::weight_t'(w3);
        return w;
    endfunction

    function automatic swpb_pkg::q16_t pick_ratio();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return swpb_pkg::ONE_Q16;
        if (r < 15)
            return swpb_pkg::ONE_Q16 + 17'd1;
        if (r < 30)
            return swpb_pkg::q16_t'($urandom_range(65537, 131071));
        if (r < 40)
            return swpb_pkg::q16_t'($urandom_range(60000, 65535));
        return swpb_pkg::q16_t'($urandom_range(0, 65536));
    endfunction

    // mostly texels that already sum to full coverage, the rest arbitrary
    function automatic swpb_pkg::texel_t pick_texel();
        int a;
        int b;
        int c;
        if ($urandom_range(0, 99) < 45)
            return texel($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255 - a);
        c = $urandom_range(0, 255 - a - b);
        unique case ($urandom_range(0, 3))
            0: return texel(255 - a - b - c, a, b, c);
            1: return texel(a, 255 - a - b - c, b, c);
            2: return texel(a, b, 255 - a - b - c, c);
            default: return texel(a, b, c, 255 - a - b - c);
        endcase
    endfunction

    function automatic logic [15:0] phase_strength(input int phase);
        unique case (phase)
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return 16'h0100;
            6: return 16'hFFFF;
            7: return 16'h0180;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_texel(input swpb_pkg::layer_t sel, input swpb_pkg::q16_t ratio,
                              input swpb_pkg::texel_t w);
        // idle a random number of cycles unless in the steady stretch
        while (!steady_run && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, w, ratio};
        s_tuser  <= sel;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic write_strength(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {swpb_pkg::REG_STRENGTH, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        // let the checker record the last accepted item before polling
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: strength at its reset value
        send_texel(2'd0, 17'd0,       texel(0, 0, 0, 0));
        send_texel(2'd1, 17'd0,       texel(255, 255, 255, 255));
        send_texel(2'd2, 17'd0,       texel(0, 255, 0, 0));
        send_texel(2'd3, 17'd0,       texel(64, 64, 64, 63));
        send_texel(2'd0, swpb_pkg::ONE_Q16,         texel(10, 20, 30, 40));
        send_texel(2'd3, swpb_pkg::ONE_Q16,         texel(255, 255, 255, 0));
        send_texel(2'd1, swpb_pkg::ONE_Q16 + 17'd1, texel(1, 2, 3, 4));
        send_texel(2'd2, 17'h1FFFF,   texel(255, 255, 255, 255));
        send_texel(2'd3, 17'h1FFFF,   texel(0, 0, 0, 0));
        send_texel(2'd0, 17'd1,       texel(0, 85, 85, 85));
        send_texel(2'd1, 17'd65535,   texel(200, 55, 0, 0));
        send_texel(2'd2, 17'd32768,   texel(255, 255, 255, 255));
        send_texel(2'd3, 17'd32768,   texel(0, 0, 0, 255));
        send_texel(2'd0, 17'd49152,   texel(0, 128, 127, 0));
        send_texel(2'd1, 17'd16384,   texel(255, 0, 0, 0));
        send_texel(2'd2, 17'd21845,   texel(3, 250, 1, 1));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                write_strength(phase_strength(phase));
            end
            steady_run <= (phase == STEADY_PHASE);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_texel(swpb_pkg::layer_t'($urandom_range(0, 3)), pick_ratio(),
                           pick_texel());
        end

        drain();
        steady_run <= 1'b0;
        // let the pipeline settle in case anything extra comes out
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("splat_weight_paint_blend regression: pass");
        else
            $display("splat_weight_paint_blend regression: fail");
        $finish;
    end

    initial begin
        #400_000;
        $display("splat_weight_paint_blend regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/swpb_pkg.sv
design/swpb_falloff.sv
design/swpb_lane.sv
design/swpb_merge.sv
design/splat_weight_paint_blend.sv
tb/splat_blend_checker.sv
tb/splat_weight_paint_blend_tb.sv
